@@ src/bbc_pkg.sv @@
// Package: shared types and constants of the bracket balance checker.
package bbc_pkg;

  localparam int SCORE_W = 64;
  localparam int COUNT_W = 7;
  localparam int STATUS_W = 2;
  localparam int CODE_W = 2;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_OPEN_PAREN = 8'h28;
  localparam logic [7:0] CH_OPEN_SQUARE = 8'h5B;
  localparam logic [7:0] CH_OPEN_CURLY = 8'h7B;
  localparam logic [7:0] CH_OPEN_ANGLE = 8'h3C;
  localparam logic [7:0] CH_CLOSE_PAREN = 8'h29;
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D;
  localparam logic [7:0] CH_CLOSE_CURLY = 8'h7D;
  localparam logic [7:0] CH_CLOSE_ANGLE = 8'h3E;

  localparam logic [CODE_W-1:0] BR_PAREN = 2'd0;
  localparam logic [CODE_W-1:0] BR_SQUARE = 2'd1;
  localparam logic [CODE_W-1:0] BR_CURLY = 2'd2;
  localparam logic [CODE_W-1:0] BR_ANGLE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_BALANCED = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INCOMPLETE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CORRUPT = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

  localparam logic FUNC_CHAR = 1'b0;
  localparam logic FUNC_EOL = 1'b1;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_CLOSE,
    OP_EOL
  } op_kind_t;

  typedef struct packed {
    op_kind_t kind;
    logic [CODE_W-1:0] code;
  } op_t;

endpackage

@@ src/bbc_ifs.sv @@
// Interfaces: character input channel and line result channel.
interface bbc_in_if;
  logic valid;
  logic ready;
  logic func;
  logic [7:0] symbol;
  modport source(output valid, output func, output symbol, input ready);
  modport sink(input valid, input func, input symbol, output ready);
endinterface

interface bbc_out_if;
  logic valid;
  logic ready;
  logic [1:0] line_status;
  logic [63:0] completion_score;
  logic [6:0] open_count;
  modport source(output valid, output line_status, output completion_score,
                 output open_count, input ready);
  modport sink(input valid, input line_status, input completion_score,
               input open_count, output ready);
endinterface

@@ src/bbc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bbc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ src/bbc_front.sv @@
// Front end: accept characters, classify brackets, drop other bytes.
module bbc_front
  import bbc_pkg::*;
(
  bbc_in_if.sink chars,
  output logic   op_valid,
  input  logic   op_ready,
  output op_t    op
);

  logic relevant;

  always_comb begin
    op.kind = OP_EOL;
    op.code = BR_PAREN;
    relevant = 1'b1;
    if (chars.func == FUNC_CHAR) begin
      unique case (chars.symbol)
        CH_OPEN_PAREN: begin op.kind = OP_PUSH; op.code = BR_PAREN; end
        CH_OPEN_SQUARE: begin op.kind = OP_PUSH; op.code = BR_SQUARE; end
        CH_OPEN_CURLY: begin op.kind = OP_PUSH; op.code = BR_CURLY; end
        CH_OPEN_ANGLE: begin op.kind = OP_PUSH; op.code = BR_ANGLE; end
        CH_CLOSE_PAREN: begin op.kind = OP_CLOSE; op.code = BR_PAREN; end
        CH_CLOSE_SQUARE: begin op.kind = OP_CLOSE; op.code = BR_SQUARE; end
        CH_CLOSE_CURLY: begin op.kind = OP_CLOSE; op.code = BR_CURLY; end
        CH_CLOSE_ANGLE: begin op.kind = OP_CLOSE; op.code = BR_ANGLE; end
        default: relevant = 1'b0;
      endcase
    end
  end

  assign op_valid = chars.valid && relevant;
  assign chars.ready = op_ready;

endmodule

@@ src/bbc_queue.sv @@
// Small FIFO of classified operations between front and back.
module bbc_queue
  import bbc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  op_t  in_op,
  output logic out_valid,
  input  logic out_ready,
  output op_t  out_op
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  op_t entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic push;
  logic pop;

  assign in_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_op = entries[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= in_op;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/bbc_back.sv @@
// Back end: bracket stack, match check, completion score walk, result register.
module bbc_back
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input  logic clk,
  input  logic rst,
  input  logic op_valid,
  output logic op_ready,
  input  op_t  op,
  bbc_out_if.source results
);

  localparam int LVL_W = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;
  logic [LVL_W-1:0] level, level_next;
  logic [LVL_W-1:0] idx, idx_next;
  logic corrupt, corrupt_next;
  logic overflow, overflow_next;
  logic [CODE_W-1:0] close_code, close_code_next;
  logic [SCORE_W-1:0] score, score_next;
  logic [STATUS_W-1:0] status_hold, status_hold_next;

  logic out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [SCORE_W-1:0] out_score;
  logic [COUNT_W-1:0] out_count;
  logic load;

  logic wr_en;
  logic [AW-1:0] rd_addr;
  logic [CODE_W-1:0] rd_data;
  logic [LVL_W-1:0] level_dec;
  logic [LVL_W-1:0] idx_dec;

  assign level_dec = level - 1'b1;
  assign idx_dec = idx - 1'b1;

  bbc_ram #(
    .WIDTH(CODE_W),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(level[AW-1:0]),
    .wr_data(op.code),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  always_comb begin
    state_next = state;
    level_next = level;
    idx_next = idx;
    corrupt_next = corrupt;
    overflow_next = overflow;
    close_code_next = close_code;
    score_next = score;
    status_hold_next = status_hold;
    op_ready = 1'b0;
    wr_en = 1'b0;
    load = 1'b0;
    rd_addr = (state == S_WALK) ? idx_dec[AW-1:0] : level_dec[AW-1:0];
    unique case (state)
      S_IDLE: begin
        if (op_valid) begin
          op_ready = 1'b1;
          unique case (op.kind)
            OP_PUSH: begin
              if (!corrupt && !overflow) begin
                if (level == LVL_W'(STACK_DEPTH)) begin
                  overflow_next = 1'b1;
                end else begin
                  wr_en = 1'b1;
                  level_next = level + 1'b1;
                end
              end
            end
            OP_CLOSE: begin
              if (!corrupt && !overflow) begin
                if (level == '0) begin
                  corrupt_next = 1'b1;
                end else begin
                  level_next = level_dec;
                  close_code_next = op.code;
                  state_next = S_CMP;
                end
              end
            end
            OP_EOL: begin
              score_next = '0;
              if (overflow) begin
                status_hold_next = ST_OVERFLOW;
                state_next = S_DONE;
              end else if (corrupt) begin
                status_hold_next = ST_CORRUPT;
                state_next = S_DONE;
              end else if (level == '0) begin
                status_hold_next = ST_BALANCED;
                state_next = S_DONE;
              end else begin
                status_hold_next = ST_INCOMPLETE;
                idx_next = level_dec;
                state_next = S_WALK;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_CMP: begin
        if (rd_data != close_code) begin
          corrupt_next = 1'b1;
        end
        state_next = S_IDLE;
      end
      S_WALK: begin
        score_next = {score[SCORE_W-3:0], 2'b00} + score
                   + {{(SCORE_W-CODE_W){1'b0}}, rd_data} + 1'b1;
        if (idx == '0) begin
          state_next = S_DONE;
        end else begin
          idx_next = idx_dec;
        end
      end
      S_DONE: begin
        if (!out_valid || results.ready) begin
          load = 1'b1;
          level_next = '0;
          corrupt_next = 1'b0;
          overflow_next = 1'b0;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    close_code <= close_code_next;
    score <= score_next;
    status_hold <= status_hold_next;
    if (load) begin
      out_status <= status_hold;
      out_score <= score;
      out_count <= COUNT_W'(level);
    end
    if (rst) begin
      state <= S_IDLE;
      level <= '0;
      corrupt <= 1'b0;
      overflow <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      level <= level_next;
      corrupt <= corrupt_next;
      overflow <= overflow_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign results.valid = out_valid;
  assign results.line_status = out_status;
  assign results.completion_score = out_score;
  assign results.open_count = out_count;

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    level <= LVL_W'(STACK_DEPTH))
    else $error("stack level above depth");

  a_cmp_from_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_CMP |-> $past(state) == S_IDLE)
    else $error("compare state not entered from idle");

  a_walk_clean: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> !corrupt && !overflow && idx < level)
    else $error("score walk on flagged line or past stack top");

  a_load_after_done: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && level == '0 && !corrupt && !overflow)
    else $error("result load did not clear line state");

endmodule

@@ src/bracket_balance_checker.sv @@
// Top level: bracket balance checker over one text line at a time.
//
// Channel chars carries one item per character (func = 0, symbol = byte)
// or an end-of-line marker (func = 1). Channel results gives one item per
// end-of-line: line_status, completion_score and open_count.
// Characters other than the eight bracket bytes are dropped at the front
// and never reach the back end. The front feeds a 4-entry op queue.
// Back-end work per op: an opener is pushed from idle, a closer reads the
// stack RAM and then compares in the compare state, an end of line for an
// incomplete line walks its open brackets (one stack RAM read per open
// entry), and every end of line then loads the result register.
// Results leave a registered output stage; while it is stalled, the back
// end holds a finished line and the queue keeps taking characters until
// it fills. The stack RAM has STACK_DEPTH entries of 2 bits.
// Synchronous reset empties the queue, clears the stack level, the line
// flags and the result valid flag; stack contents need no clearing.
module bracket_balance_checker
  import bbc_pkg::*;
#(
  parameter int STACK_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  bbc_in_if.sink     chars,
  bbc_out_if.source  results
);

  logic f_valid;
  logic f_ready;
  op_t  f_op;
  logic b_valid;
  logic b_ready;
  op_t  b_op;

  bbc_front u_front (
    .chars   (chars),
    .op_valid(f_valid),
    .op_ready(f_ready),
    .op      (f_op)
  );

  bbc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_valid (f_valid),
    .in_ready (f_ready),
    .in_op    (f_op),
    .out_valid(b_valid),
    .out_ready(b_ready),
    .out_op   (b_op)
  );

  bbc_back #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .op_valid(b_valid),
    .op_ready(b_ready),
    .op      (b_op),
    .results (results)
  );

endmodule

@@ bench/bracket_balance_checker_tb.sv @@
// Testbench: checks the bracket balance checker's line results against a line predictor.
`timescale 1ns / 1ps

module bracket_balance_checker_tb;
  import bbc_pkg::*;

  localparam int STACK_DEPTH = 64;
  localparam int LINE_LATENCY = STACK_DEPTH + 16;
  localparam int LONG_HOLD = 400;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SCORE_W-1:0] score;
    logic [COUNT_W-1:0] count;
  } line_result_t;

  function automatic int opener_of(logic [7:0] b);
    case (b)
      CH_OPEN_PAREN: return int'(BR_PAREN);
      CH_OPEN_SQUARE: return int'(BR_SQUARE);
      CH_OPEN_CURLY: return int'(BR_CURLY);
      CH_OPEN_ANGLE: return int'(BR_ANGLE);
      default: return -1;
    endcase
  endfunction

  function automatic int closer_of(logic [7:0] b);
    case (b)
      CH_CLOSE_PAREN: return int'(BR_PAREN);
      CH_CLOSE_SQUARE: return int'(BR_SQUARE);
      CH_CLOSE_CURLY: return int'(BR_CURLY);
      CH_CLOSE_ANGLE: return int'(BR_ANGLE);
      default: return -1;
    endcase
  endfunction

  function automatic logic [7:0] open_byte(logic [CODE_W-1:0] code);
    case (code)
      BR_PAREN: return CH_OPEN_PAREN;
      BR_SQUARE: return CH_OPEN_SQUARE;
      BR_CURLY: return CH_OPEN_CURLY;
      default: return CH_OPEN_ANGLE;
    endcase
  endfunction

  function automatic logic [7:0] close_byte(logic [CODE_W-1:0] code);
    case (code)
      BR_PAREN: return CH_CLOSE_PAREN;
      BR_SQUARE: return CH_CLOSE_SQUARE;
      BR_CURLY: return CH_CLOSE_CURLY;
      default: return CH_CLOSE_ANGLE;
    endcase
  endfunction

  class line_status_book;
    logic [CODE_W-1:0] open_codes[STACK_DEPTH];
    int unsigned depth;
    bit corrupt;
    bit overflow;
    line_result_t expected_lines[$];
    int unsigned error_count;

    function new();
      depth = 0;
      corrupt = 1'b0;
      overflow = 1'b0;
      error_count = 0;
    endfunction

    function int unsigned pending();
      return expected_lines.size();
    endfunction

    function void note_item(logic f, logic [7:0] b);
      int oc;
      int cc;
      line_result_t r;
      int unsigned i;
      if (f == FUNC_CHAR) begin
        if (corrupt || overflow) return;
        oc = opener_of(b);
        cc = closer_of(b);
        if (oc >= 0) begin
          if (depth >= STACK_DEPTH) begin
            overflow = 1'b1;
          end else begin
            open_codes[depth] = oc[CODE_W-1:0];
            depth++;
          end
        end else if (cc >= 0) begin
          if (depth == 0) begin
            corrupt = 1'b1;
          end else begin
            depth--;
            if (open_codes[depth] != cc[CODE_W-1:0]) corrupt = 1'b1;
          end
        end
      end else begin
        r.score = '0;
        r.count = depth[COUNT_W-1:0];
        if (overflow) begin
          r.status = ST_OVERFLOW;
        end else if (corrupt) begin
          r.status = ST_CORRUPT;
        end else if (depth > 0) begin
          r.status = ST_INCOMPLETE;
          for (i = depth; i > 0; i--) begin
            r.score = r.score * 64'd5 + 64'(open_codes[i-1]) + 64'd1;
          end
        end else begin
          r.status = ST_BALANCED;
        end
        expected_lines.insert(expected_lines.size(), r);
        depth = 0;
        corrupt = 1'b0;
        overflow = 1'b0;
      end
    endfunction

    function void check_line(logic [STATUS_W-1:0] status, logic [SCORE_W-1:0] score,
                             logic [COUNT_W-1:0] count);
      line_result_t e;
      if (expected_lines.size() == 0) begin
        $error("unexpected result: line_status=%0d completion_score=%0d open_count=%0d",
               status, score, count);
        error_count++;
        return;
      end
      e = expected_lines.pop_front();
      if (status !== e.status) begin
        $error("line_status: expected %0d, got %0d", e.status, status);
        error_count++;
      end
      if (score !== e.score) begin
        $error("completion_score: expected %0d, got %0d", e.score, score);
        error_count++;
      end
      if (count !== e.count) begin
        $error("open_count: expected %0d, got %0d", e.count, count);
        error_count++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  bbc_in_if in_ch();
  bbc_out_if out_ch();

  bracket_balance_checker #(
    .STACK_DEPTH(STACK_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .chars(in_ch.sink),
    .results(out_ch.source)
  );

  line_status_book book = new();

  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int unsigned holds_asked = 0;
  int unsigned holds_done = 0;
  int unsigned items_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != holds_asked) begin
      out_ch.ready <= 1'b0;
      hold_left <= LONG_HOLD - 1;
      holds_done <= holds_asked;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) book.note_item(in_ch.func, in_ch.symbol);
      if (out_ch.valid && out_ch.ready) begin
        book.check_line(out_ch.line_status, out_ch.completion_score, out_ch.open_count);
      end
    end
  end

  task automatic send_item(input logic f, input logic [7:0] s);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= f;
    in_ch.symbol <= s;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(FUNC_CHAR, s[i]);
    send_item(FUNC_EOL, 8'($urandom_range(255)));
  endtask

  task automatic send_repeat(input logic [7:0] b, input int n);
    for (int i = 0; i < n; i++) send_item(FUNC_CHAR, b);
  endtask

  task automatic wait_drained;
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (book.pending() > 0);
  endtask

  task automatic send_line(input int unsigned max_len, input int unsigned push_pct);
    logic [CODE_W-1:0] open_q[$];
    logic [CODE_W-1:0] c;
    int unsigned len;
    int unsigned style;
    int unsigned break_at;
    bit broken;
    len = $urandom_range(max_len);
    style = $urandom_range(99);
    break_at = $urandom_range(len);
    broken = 1'b0;
    for (int unsigned n = 0; n < len; n++) begin
      if ($urandom_range(99) < 8) begin
        send_item(FUNC_CHAR, 8'($urandom_range(255)));
      end else if (style >= 80 && style < 95 && n == break_at && !broken) begin
        broken = 1'b1;
        if (open_q.size() == 0) begin
          send_item(FUNC_CHAR, close_byte(CODE_W'($urandom_range(3))));
        end else begin
          c = open_q[$] ^ CODE_W'($urandom_range(1, 3));
          send_item(FUNC_CHAR, close_byte(c));
        end
      end else if (open_q.size() == 0 || $urandom_range(99) < push_pct) begin
        c = CODE_W'($urandom_range(3));
        open_q.insert(open_q.size(), c);
        send_item(FUNC_CHAR, open_byte(c));
      end else begin
        send_item(FUNC_CHAR, close_byte(open_q.pop_back()));
      end
    end
    if (style < 60) begin
      while (open_q.size() > 0) send_item(FUNC_CHAR, close_byte(open_q.pop_back()));
    end else if (style >= 80 && style < 95 && !broken) begin
      send_item(FUNC_CHAR, close_byte(CODE_W'($urandom_range(3))));
    end
    send_item(FUNC_EOL, 8'($urandom_range(255)));
  endtask

  initial begin
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.func <= FUNC_CHAR;
    in_ch.symbol <= 8'h00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    send_text("");
    send_text("()");
    send_text("[<{}>]");
    send_text("([{<");
    send_text(")");
    send_text("(]()");
    send_text("]((");
    send_item(FUNC_CHAR, 8'h00);
    send_item(FUNC_CHAR, 8'hFF);
    send_item(FUNC_CHAR, 8'h61);
    send_item(FUNC_EOL, 8'hFF);
    send_repeat(CH_OPEN_ANGLE, STACK_DEPTH);
    send_item(FUNC_EOL, 8'h00);
    send_repeat(CH_OPEN_CURLY, STACK_DEPTH + 1);
    send_text(")");

    for (int phase = 0; phase < 4; phase++) begin
      int unsigned target;
      case (phase)
        0: begin
          send_idle_pct = 0;
          stall_pct = 0;
          holds_asked++;
        end
        1: begin
          send_idle_pct = 47;
          stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct = 47;
        end
        default: begin
          send_idle_pct = 32;
          stall_pct = 32;
        end
      endcase
      target = items_sent + 250;
      while (items_sent < target) begin
        if ($urandom_range(99) < 5) begin
          send_line(150, $urandom_range(60, 90));
        end else begin
          send_line(16, 50);
        end
      end
      if (phase == 1) wait_drained();
    end

    wait_drained();
    repeat (LINE_LATENCY) @(posedge clk);
    if (book.error_count == 0 && book.pending() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
